[rtl/core/bis_pkg.sv]
// ============================================================================
// bis_pkg
// Shared codes and widths for the bounded integer set unit.
// ============================================================================
package bis_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_PRESENT   = 3'd0,
        ST_ABSENT    = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4,
        ST_REMOVED   = 3'd5,
        ST_NOT_FOUND = 3'd6
    } t_status;

endpackage

[rtl/core/bounded_integer_set_unit.sv]
// ============================================================================
// bounded_integer_set_unit
// Fixed-capacity set of signed 32-bit integers, dense in insertion order.
// ============================================================================
// Usage:
//   Command channel: drive i_cmd / i_value and raise start; the beat is taken
//   at a rising edge with start high and busy low. busy stays high while the
//   command runs. Command 0 queries membership, 1 inserts, 2 removes; code 3
//   behaves as a query.
//   Result channel: o_done pulses for one cycle with o_status and
//   o_fill_count (count after the command). The receiver cannot stall, so the
//   result must be captured in that cycle. busy is already low while o_done
//   is high, so the next command may be taken in the strobe cycle.
//   Scan: entries are scanned one per cycle through the single read port
//   of the entry store, stopping at the first match. A remove that hits at
//   slot s then moves the count-1-s later entries down, one entry per cycle
//   over the same port.
//   Reset (synchronous, active low) empties the set; the entry store itself
//   is not cleared, since slots at or above the count are never read.
// ============================================================================
module bounded_integer_set_unit #(
    parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bis_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [bis_pkg::VALUE_W-1:0] i_value,
    output logic                               o_done,
    output logic [bis_pkg::STATUS_W-1:0]       o_status,
    output logic [bis_pkg::FILL_W-1:0]         o_fill_count
);

    import bis_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx,   n_idx;     // slot in read data / shift dest
    logic                r_done,  n_done;
    t_status             r_status, n_status;
    logic [CMD_W-1:0]    r_cmd;
    logic [VALUE_W-1:0]  r_value;

    logic                accept;
    logic [CMD_W-1:0]    cmd_eff;
    logic [VALUE_W-1:0]  value_eff;
    logic [CNT_W:0]      idx_p1, idx_p2;
    logic                resolve, found;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr, rd_addr;
    logic [VALUE_W-1:0]  wr_data, rd_data;

    assign accept  = start && (r_state == S_IDLE);
    assign busy    = (r_state != S_IDLE);
    assign idx_p1  = {1'b0, r_idx} + (CNT_W+1)'(1);
    assign idx_p2  = {1'b0, r_idx} + (CNT_W+1)'(2);

    // The empty-set case resolves in the accept cycle, before the latch.
    assign cmd_eff   = (r_state == S_IDLE) ? i_cmd : r_cmd;
    assign value_eff = (r_state == S_IDLE) ? VALUE_W'(i_value) : r_value;

    bis_mem #(
        .DEPTH  (CAPACITY),
        .WIDTH  (VALUE_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_done   = 1'b0;
        n_status = r_status;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_idx[IDX_W-1:0];
        wr_data  = rd_data;
        resolve  = 1'b0;
        found    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    if (r_count == '0) begin
                        resolve = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // rd_data holds entry r_idx
                if (rd_data == r_value) begin
                    resolve = 1'b1;
                    found   = 1'b1;
                end else if (idx_p1 >= {1'b0, r_count}) begin
                    resolve = 1'b1;
                end else begin
                    n_idx   = idx_p1[CNT_W-1:0];
                    rd_addr = idx_p1[IDX_W-1:0];
                end
            end
            S_SHIFT: begin
                // rd_data holds entry r_idx+1; move it down
                wr_en = 1'b1;
                if (idx_p2 < {1'b0, r_count}) begin
                    n_idx   = idx_p1[CNT_W-1:0];
                    rd_addr = idx_p2[IDX_W-1:0];
                end else begin
                    n_state  = S_IDLE;
                    n_count  = r_count - CNT_W'(1);
                    n_status = ST_REMOVED;
                    n_done   = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (resolve) begin
            n_state = S_IDLE;
            n_done  = 1'b1;
            case (cmd_eff)
                CMD_INSERT: begin
                    if (found) begin
                        n_status = ST_DUPLICATE;
                    end else if (r_count >= CNT_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = r_count[IDX_W-1:0];
                        wr_data  = value_eff;
                        n_count  = r_count + CNT_W'(1);
                        n_status = ST_INSERTED;
                    end
                end
                CMD_REMOVE: begin
                    if (!found) begin
                        n_status = ST_NOT_FOUND;
                    end else if (idx_p1 < {1'b0, r_count}) begin
                        // later entries to close up; dest slot stays in r_idx
                        n_state = S_SHIFT;
                        n_done  = 1'b0;
                        rd_addr = idx_p1[IDX_W-1:0];
                    end else begin
                        n_count  = r_count - CNT_W'(1);
                        n_status = ST_REMOVED;
                    end
                end
                default: begin
                    n_status = found ? ST_PRESENT : ST_ABSENT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        if (accept) begin
            r_cmd   <= i_cmd;
            r_value <= VALUE_W'(i_value);
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_fill_count = FILL_W'(r_count);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_count_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |-> r_done)
        else $error("fill count changed without a result beat");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_done && (r_status == ST_INSERTED))
            |-> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the set by one");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_done) |-> ($past(r_state) != S_IDLE || $past(start)))
        else $error("result beat without a command in flight");

endmodule

[rtl/core/bis_mem.sv]
// ============================================================================
// bis_mem
// Entry store: one write port, one read port, registered read data.
// ============================================================================
module bis_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
